[src/shifting_array_list_defines.svh]
// Assertion macros shared by the shifting array list RTL
`ifndef SHIFTING_ARRAY_LIST_DEFINES_SVH
`define SHIFTING_ARRAY_LIST_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define SAL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition checked on the edge after the antecedent
`define SAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Invariant checked on every clock edge outside reset
`define SAL_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

[src/sal_pkg.sv]
// Types, codes and sizing constants of the shifting array list
package sal_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int COUNT_OUT_W = 7;
  localparam int INDEX_IN_W = 6;
  localparam int CMP_W = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

  localparam logic [2:0] REQ_PUSH   = 3'd0;
  localparam logic [2:0] REQ_POP    = 3'd1;
  localparam logic [2:0] REQ_INSERT = 3'd2;
  localparam logic [2:0] REQ_DELETE = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADIDX = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LO,
    CELL_FROM_HI
  } cell_op_t;

  typedef struct packed {
    logic [2:0]               req_type;
    logic [INDEX_IN_W-1:0]    index;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic [1:0]               status;
    logic [COUNT_OUT_W-1:0]   count;
    logic                     empty_res;
  } out_item_t;

endpackage

[src/shifting_array_list.sv]
// Shifting array list top level: request control, row of cells and result register
//
// Use: present a request on in_item with in_valid; it is taken when in_ready is
// also high. Requests are push, pop, insert at an index, delete at an index and
// read at an index. Each request gives exactly one result item on out_item,
// qualified by out_valid and taken when out_ready is high.
// Steps: once the request is taken, the execute step updates the cells and
// captures the read groups, and the collect step merges the groups into the
// result register.
// Pacing: a new request is taken only after the previous result is in the result
// register; the cells shift every entry at once, and the read tree has two levels.
// Stall: while a result waits, the block still takes one more request, updates
// the cells and holds its read groups in the collect step; it takes no further
// request until the waiting result goes and the held one moves into its place.
// Reset: rst_n low clears the entry count and all handshake state; the stored
// words are left as they are and are never read before they are written.
module shifting_array_list (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sal_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output sal_pkg::out_item_t out_item
);

  `include "shifting_array_list_defines.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_COLL
  } state_t;

  typedef enum logic [1:0] {
    DK_ZERO,
    DK_WORD,
    DK_NONE
  } data_kind_t;

  localparam int W = sal_pkg::WORD_W;
  localparam int CW = sal_pkg::CMP_W;

  state_t                        state_r;
  sal_pkg::in_item_t             req_r;
  logic [sal_pkg::CNT_W-1:0]     cnt_r;
  logic [sal_pkg::CNT_W-1:0]     cnt_nxt;
  logic [1:0]                    status_r;
  logic [1:0]                    status_nxt;
  data_kind_t                    kind_r;
  data_kind_t                    kind_nxt;
  logic                          out_valid_r;
  sal_pkg::out_item_t            out_r;

  logic [CW-1:0]                 k;
  logic [CW-1:0]                 n;
  logic [CW-1:0]                 rd_idx;
  logic                          exec;
  logic                          full;
  logic                          do_push;
  logic                          do_insert;
  logic                          do_delete;

  logic [W-1:0]                  word_w  [sal_pkg::DEPTH];
  logic [W-1:0]                  rd_w    [sal_pkg::DEPTH];
  logic [W-1:0]                  tree_data;
  logic                          out_free;

  assign exec = (state_r == S_EXEC);
  assign k    = CW'(req_r.index);
  assign n    = CW'(cnt_r);
  assign full = (n >= CW'(sal_pkg::DEPTH));

  // decide the request against the count as it stands before the update
  always_comb begin
    status_nxt = sal_pkg::ST_OK;
    kind_nxt   = DK_ZERO;
    cnt_nxt    = cnt_r;
    do_push    = 1'b0;
    do_insert  = 1'b0;
    do_delete  = 1'b0;
    rd_idx     = k;
    unique case (req_r.req_type)
      sal_pkg::REQ_PUSH: begin
        if (full) begin
          status_nxt = sal_pkg::ST_FULL;
        end else begin
          do_push = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      sal_pkg::REQ_POP: begin
        rd_idx = n - 1'b1;
        if (n == '0) begin
          status_nxt = sal_pkg::ST_EMPTY;
          kind_nxt   = DK_NONE;
        end else begin
          kind_nxt = DK_WORD;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      sal_pkg::REQ_INSERT: begin
        if (full) begin
          status_nxt = sal_pkg::ST_FULL;
        end else if (k > n) begin
          status_nxt = sal_pkg::ST_BADIDX;
        end else begin
          do_insert = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      sal_pkg::REQ_DELETE: begin
        if (k >= n) begin
          status_nxt = sal_pkg::ST_BADIDX;
        end else begin
          do_delete = 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      sal_pkg::REQ_READ: begin
        if (k >= n) begin
          status_nxt = sal_pkg::ST_BADIDX;
          kind_nxt   = DK_NONE;
        end else begin
          kind_nxt = DK_WORD;
        end
      end
      default: begin
        status_nxt = sal_pkg::ST_BADIDX;
      end
    endcase
  end

  for (genvar i = 0; i < sal_pkg::DEPTH; i++) begin : g_cell
    sal_pkg::cell_op_t op;
    logic [W-1:0]      lo_word;
    logic [W-1:0]      hi_word;
    logic              rd_sel;

    always_comb begin
      op = sal_pkg::CELL_HOLD;
      if (exec) begin
        if (do_push && CW'(i) == n) begin
          op = sal_pkg::CELL_LOAD;
        end else if (do_insert && CW'(i) == k) begin
          op = sal_pkg::CELL_LOAD;
        end else if (do_insert && CW'(i) > k) begin
          op = sal_pkg::CELL_FROM_LO;
        end else if (do_delete && CW'(i) >= k) begin
          op = sal_pkg::CELL_FROM_HI;
        end
      end
    end

    if (i == 0) begin : g_lo_edge
      assign lo_word = '0;
    end else begin : g_lo_mid
      assign lo_word = word_w[i-1];
    end

    if (i == sal_pkg::DEPTH - 1) begin : g_hi_edge
      assign hi_word = word_w[i];
    end else begin : g_hi_mid
      assign hi_word = word_w[i+1];
    end

    assign rd_sel = exec && (CW'(i) == rd_idx);

    sal_cell u_cell (
      .clk     (clk),
      .op      (op),
      .value   (req_r.value),
      .lo_word (lo_word),
      .hi_word (hi_word),
      .rd_sel  (rd_sel),
      .word    (word_w[i]),
      .rd_word (rd_w[i])
    );
  end

  sal_rd_tree u_rd_tree (
    .clk   (clk),
    .en    (exec),
    .words (rd_w),
    .data  (tree_data)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_item;
            state_r <= S_EXEC;
          end
          if (out_valid_r && out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_EXEC: begin
          cnt_r    <= cnt_nxt;
          status_r <= status_nxt;
          kind_r   <= kind_nxt;
          state_r  <= S_COLL;
          if (out_valid_r && out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_COLL: begin
          if (out_free) begin
            unique case (kind_r)
              DK_WORD: out_r.data <= tree_data;
              DK_NONE: out_r.data <= '1;
              default: out_r.data <= '0;
            endcase
            out_r.status    <= status_r;
            out_r.count     <= sal_pkg::COUNT_OUT_W'(cnt_r);
            out_r.empty_res <= (cnt_r == '0);
            out_valid_r     <= 1'b1;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `SAL_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= sal_pkg::CNT_W'(sal_pkg::DEPTH), "count beyond capacity")
  `SAL_ASSERT_NEXT(a_exec_to_coll, state_r == S_EXEC, state_r == S_COLL, "execute not followed by collect")
  `SAL_ASSERT_IMPL(a_full_count, out_valid && out_item.status == sal_pkg::ST_FULL, out_item.count == sal_pkg::COUNT_OUT_W'(sal_pkg::DEPTH), "full reported below capacity")
  `SAL_ASSERT_IMPL(a_empty_pop, out_valid && out_item.status == sal_pkg::ST_EMPTY, out_item.empty_res && out_item.data == -32'sd1, "empty result without marker word")
  `SAL_ASSERT_NEXT(a_cnt_stable, state_r != S_EXEC, $stable(cnt_r) || $past(state_r) == S_EXEC, "count moved outside execute")

endmodule

[src/sal_cell.sv]
// One storage cell of the shifting array list: holds a word, loads or shifts
module sal_cell (
  input  logic                               clk,
  input  sal_pkg::cell_op_t                  op,
  input  logic [sal_pkg::WORD_W-1:0]         value,
  input  logic [sal_pkg::WORD_W-1:0]         lo_word,
  input  logic [sal_pkg::WORD_W-1:0]         hi_word,
  input  logic                               rd_sel,
  output logic [sal_pkg::WORD_W-1:0]         word,
  output logic [sal_pkg::WORD_W-1:0]         rd_word
);

  logic [sal_pkg::WORD_W-1:0] word_r;
  logic [sal_pkg::WORD_W-1:0] word_nxt;

  always_comb begin
    unique case (op)
      sal_pkg::CELL_HOLD:    word_nxt = word_r;
      sal_pkg::CELL_LOAD:    word_nxt = value;
      sal_pkg::CELL_FROM_LO: word_nxt = lo_word;
      sal_pkg::CELL_FROM_HI: word_nxt = hi_word;
      default:               word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word    = word_r;
  // drive the word onto the read bus only when selected
  assign rd_word = word_r & {sal_pkg::WORD_W{rd_sel}};

endmodule

[src/sal_rd_tree.sv]
// Registered OR tree that collects the selected cell's word
module sal_rd_tree (
  input  logic                       clk,
  input  logic                       en,
  input  logic [sal_pkg::WORD_W-1:0] words [sal_pkg::DEPTH],
  output logic [sal_pkg::WORD_W-1:0] data
);

  localparam int GRP  = 8;
  localparam int NGRP = (sal_pkg::DEPTH + GRP - 1) / GRP;

  logic [sal_pkg::WORD_W-1:0] grp_r   [NGRP];
  logic [sal_pkg::WORD_W-1:0] grp_nxt [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if (g * GRP + j < sal_pkg::DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | words[g * GRP + j];
        end
      end
    end
  end

  // capture only on the update cycle; hold the groups while the result waits
  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  always_comb begin
    data = '0;
    for (int g = 0; g < NGRP; g++) begin
      data = data | grp_r[g];
    end
  end

endmodule
